// ===== design/sps_pkg.sv =====
// ---------------------------------------------------------------------------
// sps_pkg: shared types and constants for the shortest path heap search
// Action and status codes, distance marks and the control bundles that
// pass between the sequencer and the heap unit.
// ---------------------------------------------------------------------------
package sps_pkg;

   localparam int IN_NODE_W   = 10;
   localparam int IN_WEIGHT_W = 16;
   localparam int CFG_W       = 11;
   localparam int DIST_W      = 30;
   localparam int INF_W       = 31;

   localparam logic [INF_W-1:0]  INF_MARK = 31'h4000_0000;
   localparam logic [DIST_W-1:0] DIST_SAT = 30'h3FFF_FFFF;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clr;
   } heap_ctl_type;

   typedef struct packed {
      logic busy;
      logic empty;
   } heap_sts_type;

endpackage

// ===== design/sps_ram.sv =====
// ---------------------------------------------------------------------------
// sps_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module sps_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sps_heap.sv =====
// ---------------------------------------------------------------------------
// sps_heap: binary min-heap unit
// Push sifts up, pop sifts down, one RAM access a step.
// ---------------------------------------------------------------------------
module sps_heap #(
   parameter int NODE_W = 10,
   parameter int DEPTH  = 8192
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sps_pkg::heap_ctl_type      ctl,
   input  logic [NODE_W-1:0]          push_node,
   input  logic [sps_pkg::DIST_W-1:0] push_dist,
   output sps_pkg::heap_sts_type      sts,
   output logic [NODE_W-1:0]          pop_node
);
   import sps_pkg::*;

   localparam int HI_W = $clog2(DEPTH);
   localparam int SZ_W = $clog2(DEPTH + 1);
   localparam int LW   = HI_W + 2;
   localparam int IW   = NODE_W + DIST_W;

   typedef enum logic [7:0] {
      H_IDLE     = 8'b0000_0001,
      H_PUP_CHK  = 8'b0000_0010,
      H_PUP_WAIT = 8'b0000_0100,
      H_POP_A    = 8'b0000_1000,
      H_POP_B    = 8'b0001_0000,
      H_DN_CHK   = 8'b0010_0000,
      H_DN_L     = 8'b0100_0000,
      H_DN_R     = 8'b1000_0000
   } hstate_type;

   hstate_type        state_ff, state_in;
   logic [SZ_W-1:0]   size_ff, size_in;
   logic [HI_W-1:0]   idx_ff, idx_in;
   logic [IW-1:0]     item_ff, item_in;
   logic [IW-1:0]     ldat_ff, ldat_in;
   logic [NODE_W-1:0] got_ff, got_in;

   logic            wr_en;
   logic [HI_W-1:0] wr_addr, rd_addr;
   logic [IW-1:0]   wr_data, rd_data;

   logic [HI_W-1:0] parent;
   logic [LW-1:0]   lft, rgt, size_x;

   sps_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign parent = HI_W'((idx_ff - HI_W'(1)) >> 1);
   assign lft    = (LW'(idx_ff) << 1) + LW'(1);
   assign rgt    = lft + LW'(1);
   assign size_x = LW'(size_ff);

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      idx_in   = idx_ff;
      item_in  = item_ff;
      ldat_in  = ldat_ff;
      got_in   = got_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = item_ff;
      rd_addr  = '0;
      unique case (state_ff)
         H_IDLE: begin
            if (ctl.clr) begin
               size_in = '0;
            end else if (ctl.push) begin
               if (32'(size_ff) < DEPTH) begin
                  idx_in   = HI_W'(size_ff);
                  size_in  = size_ff + SZ_W'(1);
                  item_in  = {push_node, push_dist};
                  state_in = H_PUP_CHK;
               end
            end else if (ctl.pop && size_ff != '0) begin
               size_in  = size_ff - SZ_W'(1);
               rd_addr  = '0;
               state_in = H_POP_A;
            end
         end
         H_PUP_CHK: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = H_IDLE;
            end else begin
               rd_addr  = parent;
               state_in = H_PUP_WAIT;
            end
         end
         H_PUP_WAIT: begin
            wr_en = 1'b1;
            if (rd_data[DIST_W-1:0] > item_ff[DIST_W-1:0]) begin
               wr_data  = rd_data;
               idx_in   = parent;
               state_in = H_PUP_CHK;
            end else begin
               state_in = H_IDLE;
            end
         end
         H_POP_A: begin
            got_in = rd_data[IW-1 -: NODE_W];
            if (size_ff == '0) begin
               state_in = H_IDLE;
            end else begin
               rd_addr  = HI_W'(size_ff);
               state_in = H_POP_B;
            end
         end
         H_POP_B: begin
            item_in  = rd_data;
            idx_in   = '0;
            state_in = H_DN_CHK;
         end
         H_DN_CHK: begin
            if (lft < size_x) begin
               rd_addr  = lft[HI_W-1:0];
               state_in = H_DN_L;
            end else begin
               wr_en    = 1'b1;
               state_in = H_IDLE;
            end
         end
         H_DN_L: begin
            ldat_in = rd_data;
            if (rgt < size_x) begin
               rd_addr  = rgt[HI_W-1:0];
               state_in = H_DN_R;
            end else if (rd_data[DIST_W-1:0] < item_ff[DIST_W-1:0]) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = lft[HI_W-1:0];
               state_in = H_DN_CHK;
            end else begin
               wr_en    = 1'b1;
               state_in = H_IDLE;
            end
         end
         H_DN_R: begin
            wr_en = 1'b1;
            priority if (rd_data[DIST_W-1:0] < ldat_ff[DIST_W-1:0] &&
                         rd_data[DIST_W-1:0] < item_ff[DIST_W-1:0]) begin
               wr_data  = rd_data;
               idx_in   = rgt[HI_W-1:0];
               state_in = H_DN_CHK;
            end else if (ldat_ff[DIST_W-1:0] < item_ff[DIST_W-1:0]) begin
               wr_data  = ldat_ff;
               idx_in   = lft[HI_W-1:0];
               state_in = H_DN_CHK;
            end else begin
               state_in = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
      idx_ff  <= idx_in;
      item_ff <= item_in;
      ldat_ff <= ldat_in;
      got_ff  <= got_in;
   end

   assign sts.busy  = (state_ff != H_IDLE);
   assign sts.empty = (size_ff == '0);
   assign pop_node  = got_ff;

endmodule

// ===== design/shortest_path_heap_search_top.sv =====
// ---------------------------------------------------------------------------
// shortest_path_heap_search_top: Dijkstra search over a stored edge list
// Clear, add edge, run from a source with a binary min-heap, read distance.
//
//   channel | dir | handshake        | beat carries
//   req     | in  | valid / stall    | action, edge_from, edge_to, edge_weight,
//           |     |                  | source_node, query_node
//   rsp     | out | valid / stall    | status, distance, reachable
//   csr     | in  | valid / ready    | node_count
//
// After reset a sweep fills the list heads and the node table; no beat is
// taken meanwhile. csr is always ready.
// req_stall is high while an item is at work; a waiting result beat holds in
// the output register and does not block the next request.
// ---------------------------------------------------------------------------
module shortest_path_heap_search_top #(
   parameter int MAX_NODES   = 1024,
   parameter int MAX_EDGES   = 4096,
   parameter int HEAP_DEPTH  = 8192,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [sps_pkg::IN_NODE_W-1:0]   req_edge_from,
   input  logic [sps_pkg::IN_NODE_W-1:0]   req_edge_to,
   input  logic [sps_pkg::IN_WEIGHT_W-1:0] req_edge_weight,
   input  logic [sps_pkg::IN_NODE_W-1:0]   req_source_node,
   input  logic [sps_pkg::IN_NODE_W-1:0]   req_query_node,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [sps_pkg::DIST_W-1:0]      rsp_distance,
   output logic                            rsp_reachable,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sps_pkg::CFG_W-1:0]       csr_node_count
);
   import sps_pkg::*;

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int NC_W    = $clog2(MAX_NODES + 1);
   localparam int EC_W    = $clog2(MAX_EDGES + 1);
   localparam int EA_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NRW     = INF_W + 1;
   localparam int ERW     = NODE_W + WEIGHT_BITS + EC_W;
   localparam int NC_RST  = (MAX_NODES < 1024) ? MAX_NODES : 1024;
   localparam logic [EC_W-1:0]   EMPTY_LINK = EC_W'(MAX_EDGES);
   localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(MAX_NODES - 1);

   typedef enum logic [15:0] {
      S_INIT     = 16'h0001,
      S_IDLE     = 16'h0002,
      S_CLR      = 16'h0004,
      S_ADD_RD   = 16'h0008,
      S_RUN_CLR  = 16'h0010,
      S_RUN_SEED = 16'h0020,
      S_POP      = 16'h0040,
      S_POPW     = 16'h0080,
      S_U_RD     = 16'h0100,
      S_HEAD     = 16'h0200,
      S_EDGE     = 16'h0400,
      S_EDGE_RD  = 16'h0800,
      S_V_RD     = 16'h1000,
      S_PUSHW    = 16'h2000,
      S_RD_RD    = 16'h4000,
      S_DONE     = 16'h8000
   } state_type;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in;
   logic [NC_W-1:0]   node_count_ff, node_count_in;
   logic [EC_W-1:0]   edges_used_ff, edges_used_in;
   logic [NODE_W-1:0] from_ff, from_in, to_ff, to_in, src_ff, src_in;
   logic [NODE_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [WEIGHT_BITS-1:0] wt_ff, wt_in;
   logic [DIST_W-1:0] du_ff, du_in, sum_ff, sum_in;
   logic [EC_W-1:0]   e_ff, e_in, link_ff, link_in;
   status_type        status_ff, status_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              reach_ff, reach_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_reach_ff, rsp_reach_in;

   // node table: {settled, best distance}
   logic              nd_we;
   logic [NODE_W-1:0] nd_waddr, nd_raddr;
   logic [NRW-1:0]    nd_wdata, nd_rdata;
   // list heads
   logic              hd_we;
   logic [NODE_W-1:0] hd_waddr, hd_raddr;
   logic [EC_W-1:0]   hd_wdata, hd_rdata;
   // edge store: {target, cost, link}
   logic              eg_we;
   logic [EA_W-1:0]   eg_waddr, eg_raddr;
   logic [ERW-1:0]    eg_wdata, eg_rdata;

   heap_ctl_type      heap_ctl;
   heap_sts_type      heap_sts;
   logic [NODE_W-1:0] heap_pop_node;

   logic              req_take, out_free, sweep_last;
   logic [NODE_W-1:0] eg_target;
   logic [WEIGHT_BITS-1:0] eg_cost;
   logic [EC_W-1:0]   eg_link;
   logic [INF_W-1:0]  sum_raw;
   logic [NC_W-1:0]   csr_clamped;

   sps_ram #(.WIDTH(NRW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock (clock), .wr_en (nd_we), .wr_addr (nd_waddr), .wr_data (nd_wdata),
      .rd_addr (nd_raddr), .rd_data (nd_rdata)
   );

   sps_ram #(.WIDTH(EC_W), .DEPTH(MAX_NODES)) u_head_ram (
      .clock (clock), .wr_en (hd_we), .wr_addr (hd_waddr), .wr_data (hd_wdata),
      .rd_addr (hd_raddr), .rd_data (hd_rdata)
   );

   sps_ram #(.WIDTH(ERW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock), .wr_en (eg_we), .wr_addr (eg_waddr), .wr_data (eg_wdata),
      .rd_addr (eg_raddr), .rd_data (eg_rdata)
   );

   sps_heap #(.NODE_W(NODE_W), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock     (clock),
      .reset     (reset),
      .ctl       (heap_ctl),
      .push_node (v_ff),
      .push_dist (sum_ff),
      .sts       (heap_sts),
      .pop_node  (heap_pop_node)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_last = (cnt_ff == LAST_NODE);
   assign csr_ready  = 1'b1;

   assign eg_target = eg_rdata[ERW-1 -: NODE_W];
   assign eg_cost   = eg_rdata[EC_W +: WEIGHT_BITS];
   assign eg_link   = eg_rdata[EC_W-1:0];
   // path sum, saturate below the infinity mark
   assign sum_raw   = {1'b0, du_ff} + INF_W'(eg_cost);

   // clamp written node count into 1..MAX_NODES
   always_comb begin
      priority if (csr_node_count == '0) begin
         csr_clamped = NC_W'(1);
      end else if (32'(csr_node_count) > MAX_NODES) begin
         csr_clamped = NC_W'(MAX_NODES);
      end else begin
         csr_clamped = NC_W'(csr_node_count);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      node_count_in = node_count_ff;
      edges_used_in = edges_used_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      src_in        = src_ff;
      wt_in         = wt_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      du_in         = du_ff;
      sum_in        = sum_ff;
      e_in          = e_ff;
      link_in       = link_ff;
      status_in     = status_ff;
      dist_in       = dist_ff;
      reach_in      = reach_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_reach_in  = rsp_reach_ff;

      nd_we    = 1'b0;
      nd_waddr = cnt_ff;
      nd_wdata = {1'b0, INF_MARK};
      nd_raddr = '0;
      hd_we    = 1'b0;
      hd_waddr = cnt_ff;
      hd_wdata = EMPTY_LINK;
      hd_raddr = '0;
      eg_we    = 1'b0;
      eg_waddr = EA_W'(edges_used_ff);
      eg_wdata = {to_ff, wt_ff, hd_rdata};
      eg_raddr = EA_W'(e_ff);
      heap_ctl = '0;

      if (csr_valid && csr_ready) begin
         node_count_in = csr_clamped;
      end

      unique case (state_ff)
         S_INIT: begin
            // fill heads and node table after reset
            nd_we  = 1'b1;
            hd_we  = 1'b1;
            cnt_in = cnt_ff + NODE_W'(1);
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               from_in   = NODE_W'(req_edge_from);
               to_in     = NODE_W'(req_edge_to);
               src_in    = NODE_W'(req_source_node);
               wt_in     = WEIGHT_BITS'(req_edge_weight);
               status_in = ST_OK;
               dist_in   = '0;
               reach_in  = 1'b0;
               cnt_in    = '0;
               unique case (action_type'(req_action))
                  ACT_CLEAR: begin
                     edges_used_in = '0;
                     state_in      = S_CLR;
                  end
                  ACT_ADD: begin
                     priority if (32'(req_edge_from) >= 32'(node_count_ff) ||
                                  32'(req_edge_to) >= 32'(node_count_ff)) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else if (edges_used_ff == EMPTY_LINK) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        hd_raddr = NODE_W'(req_edge_from);
                        state_in = S_ADD_RD;
                     end
                  end
                  ACT_RUN: begin
                     if (32'(req_source_node) >= 32'(node_count_ff)) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_RUN_CLR;
                     end
                  end
                  ACT_READ: begin
                     if (32'(req_query_node) >= 32'(node_count_ff)) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        nd_raddr = NODE_W'(req_query_node);
                        state_in = S_RD_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CLR: begin
            hd_we  = 1'b1;
            cnt_in = cnt_ff + NODE_W'(1);
            if (sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_ADD_RD: begin
            // prepend: new edge links to old head
            eg_we         = 1'b1;
            hd_we         = 1'b1;
            hd_waddr      = from_ff;
            hd_wdata      = edges_used_ff;
            edges_used_in = edges_used_ff + EC_W'(1);
            state_in      = S_DONE;
         end
         S_RUN_CLR: begin
            nd_we        = 1'b1;
            heap_ctl.clr = 1'b1;
            cnt_in       = cnt_ff + NODE_W'(1);
            if (sweep_last) begin
               state_in = S_RUN_SEED;
            end
         end
         S_RUN_SEED: begin
            nd_we         = 1'b1;
            nd_waddr      = src_ff;
            nd_wdata      = '0;
            v_in          = src_ff;
            sum_in        = '0;
            state_in      = S_POPW;
         end
         S_POPW: begin
            // seed push goes out here, from the registered v and sum, once the heap is idle
            if (!heap_sts.busy) begin
               heap_ctl.push = 1'b1;
               state_in      = S_POP;
            end
         end
         S_POP: begin
            priority if (heap_sts.busy) begin
               state_in = S_POP;
            end else if (heap_sts.empty) begin
               state_in = S_DONE;
            end else begin
               heap_ctl.pop = 1'b1;
               state_in     = S_U_RD;
            end
         end
         S_U_RD: begin
            // wait for the pop, then fetch the node
            if (!heap_sts.busy) begin
               u_in     = heap_pop_node;
               nd_raddr = heap_pop_node;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (nd_rdata[INF_W]) begin
               state_in = S_POP;
            end else begin
               nd_we    = 1'b1;
               nd_waddr = u_ff;
               nd_wdata = {1'b1, nd_rdata[INF_W-1:0]};
               du_in    = nd_rdata[DIST_W-1:0];
               hd_raddr = u_ff;
               e_in     = EMPTY_LINK;
               state_in = S_PUSHW;
               link_in  = EMPTY_LINK;
            end
         end
         S_PUSHW: begin
            // first pass takes the list head; later passes wait on a push
            if (!heap_sts.busy) begin
               if (e_ff == EMPTY_LINK && link_ff == EMPTY_LINK) begin
                  e_in = hd_rdata;
               end else begin
                  e_in = link_ff;
               end
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (e_ff == EMPTY_LINK) begin
               state_in = S_POP;
            end else begin
               eg_raddr = EA_W'(e_ff);
               state_in = S_EDGE_RD;
            end
         end
         S_EDGE_RD: begin
            link_in = eg_link;
            v_in    = eg_target;
            if (sum_raw > INF_W'(DIST_SAT)) begin
               sum_in = DIST_SAT;
            end else begin
               sum_in = sum_raw[DIST_W-1:0];
            end
            if (32'(eg_target) >= 32'(node_count_ff)) begin
               e_in     = eg_link;
               state_in = S_EDGE;
            end else begin
               nd_raddr = eg_target;
               state_in = S_V_RD;
            end
         end
         S_V_RD: begin
            if (nd_rdata[INF_W-1:0] > {1'b0, sum_ff}) begin
               // hold the current edge; advance to the link once the push is done
               nd_we         = 1'b1;
               nd_waddr      = v_ff;
               nd_wdata      = {nd_rdata[INF_W], 1'b0, sum_ff};
               heap_ctl.push = 1'b1;
               state_in      = S_PUSHW;
            end else begin
               e_in     = link_ff;
               state_in = S_EDGE;
            end
         end
         S_RD_RD: begin
            if (nd_rdata[INF_W-1:0] < INF_MARK) begin
               dist_in  = nd_rdata[DIST_W-1:0];
               reach_in = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_dist_in   = dist_ff;
               rsp_reach_in  = reach_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         node_count_ff <= NC_W'(NC_RST);
         edges_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         node_count_ff <= node_count_in;
         edges_used_ff <= edges_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      from_ff       <= from_in;
      to_ff         <= to_in;
      src_ff        <= src_in;
      wt_ff         <= wt_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      du_ff         <= du_in;
      sum_ff        <= sum_in;
      e_ff          <= e_in;
      link_ff       <= link_in;
      status_ff     <= status_in;
      dist_ff       <= dist_in;
      reach_ff      <= reach_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_reach_ff  <= rsp_reach_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_reachable = rsp_reach_ff;

   // an accepted request holds the input side until its result is built
   a_take_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request accepted twice in a row");

   // heap commands only reach an idle heap
   a_heap_idle_cmd: assert property (@(posedge clock) disable iff (reset)
      (heap_ctl.push || heap_ctl.pop) |-> !heap_sts.busy)
      else $error("heap command while heap busy");

   // edge fill count never passes the store size
   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      edges_used_ff <= EMPTY_LINK)
      else $error("edge count beyond store");

   // a reached node only comes with an ok status
   a_reach_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reachable) |-> (rsp_status == ST_OK))
      else $error("reachable flag with error status");

endmodule

// ===== test/shortest_path_heap_search_top_tb.sv =====
// ---------------------------------------------------------------------------
// shortest_path_heap_search_top_tb: self-checking bench for the path search
// Drives clear, add edge, run and read beats, with random idle bursts on
// both channels. It predicts each response from its own copy of the graph,
// heap and distance table and compares every field. It also steps the node
// count through its extremes.
// ---------------------------------------------------------------------------
module shortest_path_heap_search_top_tb;
   import sps_pkg::*;

   localparam int NODES      = 1024;
   localparam int EDGES      = 4096;
   localparam int HEAP_SLOTS = 8192;
   localparam int CYCLE_CAP  = 20_000_000;

   typedef struct {
      status_type      status;
      logic [DIST_W-1:0] distance;
      logic            reachable;
   } path_reply;

   // Prediction of the block plus the queue of replies still owed.
   class path_scoreboard;
      int unsigned node_limit;
      int unsigned edge_dst[EDGES];
      int unsigned edge_wt[EDGES];
      int unsigned edge_next[EDGES];
      int unsigned head[NODES];
      int unsigned edge_fill;
      int unsigned dist_tab[NODES];
      bit          done_tab[NODES];
      int unsigned heap_node[HEAP_SLOTS];
      int unsigned heap_dist[HEAP_SLOTS];
      int unsigned heap_fill;
      path_reply   owed[$];
      int          errors;
      int          n_full, n_range, n_reach, n_runs;

      function new();
         node_limit = NODES;
         foreach (head[i]) head[i] = EDGES;
         foreach (dist_tab[i]) dist_tab[i] = INF_MARK;
         edge_fill = 0;
         heap_fill = 0;
         errors    = 0;
      endfunction

      function void set_count(int unsigned value);
         int unsigned v;
         v = value & 11'h7FF;
         if (v == 0) v = 1;
         if (v > NODES) v = NODES;
         node_limit = v;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         int unsigned tn, td;
         tn = heap_node[a]; td = heap_dist[a];
         heap_node[a] = heap_node[b]; heap_dist[a] = heap_dist[b];
         heap_node[b] = tn; heap_dist[b] = td;
      endfunction

      function void heap_insert(int unsigned node, int unsigned ins_dist);
         int unsigned i, p;
         if (heap_fill >= HEAP_SLOTS) return;
         i = heap_fill++;
         heap_node[i] = node;
         heap_dist[i] = ins_dist;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_dist[p] > heap_dist[i]) begin
               swap_slots(p, i);
               i = p;
            end else break;
         end
      endfunction

      function bit heap_take(output int unsigned node, output int unsigned got_dist);
         int unsigned i, l, r;
         i = 0;
         if (heap_fill == 0) return 0;
         heap_fill--;
         swap_slots(0, heap_fill);
         node = heap_node[heap_fill];
         got_dist = heap_dist[heap_fill];
         while (i * 2 + 1 < heap_fill) begin
            l = i * 2 + 1;
            r = l + 1;
            if (r < heap_fill && heap_dist[r] < heap_dist[l] &&
                heap_dist[r] < heap_dist[i]) begin
               swap_slots(r, i);
               i = r;
            end else if (heap_dist[l] < heap_dist[i]) begin
               swap_slots(l, i);
               i = l;
            end else break;
         end
         return 1;
      endfunction

      function void search_from(int unsigned src);
         int unsigned u, d, e, v;
         longint unsigned sum;
         foreach (dist_tab[i]) begin
            dist_tab[i] = INF_MARK;
            done_tab[i] = 0;
         end
         dist_tab[src] = 0;
         heap_fill = 0;
         heap_insert(src, 0);
         while (heap_take(u, d)) begin
            if (u >= NODES || done_tab[u]) continue;
            done_tab[u] = 1;
            for (e = head[u]; e < EDGES; e = edge_next[e]) begin
               v = edge_dst[e];
               if (v >= node_limit) continue;
               sum = longint'(dist_tab[u]) + edge_wt[e];
               if (sum > DIST_SAT) sum = DIST_SAT;
               if (longint'(dist_tab[v]) > sum) begin
                  dist_tab[v] = int'(sum);
                  heap_insert(v, int'(sum));
               end
            end
         end
      endfunction

      function void note_request(action_type act, int unsigned from, int unsigned to,
                                 int unsigned wt, int unsigned src, int unsigned qry);
         path_reply r;
         r.status = ST_OK;
         r.distance = '0;
         r.reachable = 0;
         case (act)
            ACT_CLEAR: begin
               foreach (head[i]) head[i] = EDGES;
               edge_fill = 0;
            end
            ACT_ADD: begin
               if (from >= node_limit || to >= node_limit) r.status = ST_RANGE;
               else if (edge_fill >= EDGES) r.status = ST_FULL;
               else begin
                  edge_dst[edge_fill]  = to;
                  edge_wt[edge_fill]   = wt;
                  edge_next[edge_fill] = head[from];
                  head[from] = edge_fill;
                  edge_fill++;
               end
            end
            ACT_RUN: begin
               if (src >= node_limit) r.status = ST_RANGE;
               else begin
                  search_from(src);
                  n_runs++;
               end
            end
            default: begin
               if (qry >= node_limit) r.status = ST_RANGE;
               else if (dist_tab[qry] < INF_MARK) begin
                  r.distance = dist_tab[qry];
                  r.reachable = 1;
                  n_reach++;
               end
            end
         endcase
         if (r.status == ST_FULL) n_full++;
         if (r.status == ST_RANGE) n_range++;
         owed.push_back(r);
      endfunction

      function void check_response(logic [1:0] st, logic [DIST_W-1:0] dist_val,
                                   logic reach);
         path_reply x;
         if (owed.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
            return;
         end
         x = owed.pop_front();
         if (st !== x.status) begin
            $error("status: expected %0d, actual %0d", x.status, st);
            errors++;
         end
         if (dist_val !== x.distance) begin
            $error("distance: expected %0d, actual %0d", x.distance, dist_val);
            errors++;
         end
         if (reach !== x.reachable) begin
            $error("reachable: expected %0d, actual %0d", x.reachable, reach);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_stall;
   logic [1:0]             req_action = ACT_CLEAR;
   logic [IN_NODE_W-1:0]   req_edge_from = '0;
   logic [IN_NODE_W-1:0]   req_edge_to = '0;
   logic [IN_WEIGHT_W-1:0] req_edge_weight = '0;
   logic [IN_NODE_W-1:0]   req_source_node = '0;
   logic [IN_NODE_W-1:0]   req_query_node = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 0;
   logic [1:0]             rsp_status;
   logic [DIST_W-1:0]      rsp_distance;
   logic                   rsp_reachable;
   logic                   csr_valid = 0;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_node_count = '0;

   path_scoreboard sb = new();
   bit quiet = 0;       // no idling on either side
   bit long_hold = 0;   // receiver holds off for a long stretch
   int cycles = 0;
   int beats = 0;
   int unsigned cur_count = NODES;

   shortest_path_heap_search_top dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Check every response beat against the oldest expectation.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_distance, rsp_reachable);

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (3000) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 0;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Offer one request beat and hold it until accepted.
   task automatic send_beat(action_type act, int unsigned from, int unsigned to,
                            int unsigned wt, int unsigned src, int unsigned qry);
      req_valid       <= 1;
      req_action      <= act;
      req_edge_from   <= IN_NODE_W'(from);
      req_edge_to     <= IN_NODE_W'(to);
      req_edge_weight <= IN_WEIGHT_W'(wt);
      req_source_node <= IN_NODE_W'(src);
      req_query_node  <= IN_NODE_W'(qry);
      do @(posedge clock); while (req_stall);
      sb.note_request(act, from, to, wt, src, qry);
      beats++;
      // drop valid for a random gap now and then
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic add_edge(int unsigned from, int unsigned to, int unsigned wt);
      send_beat(ACT_ADD, from, to, wt, $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   task automatic run_from(int unsigned src);
      send_beat(ACT_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 65535), src, $urandom_range(0, 1023));
   endtask

   task automatic read_node(int unsigned qry);
      send_beat(ACT_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 65535), $urandom_range(0, 1023), qry);
   endtask

   task automatic clear_graph();
      send_beat(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 65535), $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   // Drain all owed replies, settle, then write the node count.
   task automatic write_count(int unsigned value);
      req_valid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid      <= 1;
      csr_node_count <= CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_count(value);
      cur_count = sb.node_limit;
   endtask

   // Random mix: mostly well-formed build/run/read sequences, some noise.
   task automatic random_phase(int unsigned quota);
      int unsigned start, k, n;
      start = beats;
      while (beats - start < quota) begin
         n = cur_count;
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 3) == 0) clear_graph();
            k = $urandom_range(1, (3 * n > 40) ? 40 : 3 * n);
            repeat (k) add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                            : $urandom_range(0, 300));
            run_from($urandom_range(0, n - 1));
            repeat ($urandom_range(4, 8)) read_node($urandom_range(0, n - 1));
         end else begin
            repeat ($urandom_range(1, 6))
               send_beat(action_type'($urandom_range(0, 3)), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 65535),
                         $urandom_range(0, 1023), $urandom_range(0, 1023));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed: extremes, every action, range and kept-result cases.
      read_node(0);
      read_node(1023);
      add_edge(0, 1023, 16'hFFFF);
      add_edge(1023, 0, 0);
      add_edge(5, 5, 0);
      add_edge(0, 1023, 7);
      run_from(0);
      read_node(1023);
      read_node(0);
      read_node(5);
      clear_graph();
      read_node(1023);        // distances survive a clear
      run_from(1023);
      read_node(0);
      write_count(0);         // zero acts as one
      add_edge(0, 0, 3);
      add_edge(0, 1, 3);
      run_from(1);
      run_from(0);
      read_node(0);
      read_node(1);
      write_count(8);
      add_edge(2, 7, 9);
      add_edge(2, 3, 1);
      write_count(4);         // edge to node 7 is now beyond the count
      run_from(2);
      read_node(3);
      write_count(2047);      // above the maximum acts as the maximum
      read_node(7);
      clear_graph();

      write_count(1);    random_phase(150);
      write_count(2);    random_phase(200);
      write_count(16);
      long_hold = 1;     // back up the response path
      random_phase(250);
      write_count(1024); random_phase(200);
      write_count(50);   random_phase(250);
      write_count(7);    random_phase(200);
      write_count($urandom_range(3, 300)); random_phase(250);
      quiet = 1;
      write_count(24);   random_phase(250);

      req_valid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d request beats, %0d searches, %0d reached reads",
               beats, sb.n_runs, sb.n_reach);
      $display("%0d store-full and %0d out-of-range replies", sb.n_full, sb.n_range);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sps_pkg.sv
design/sps_ram.sv
design/sps_heap.sv
design/shortest_path_heap_search_top.sv
test/shortest_path_heap_search_top_tb.sv
